FILE: sv/rapr_pkg.sv
// ============================================================================
// rapr_pkg - shared types and constants
// Status codes, header layout and the per-item result record for the
// addressed packet receiver.
// ============================================================================
`default_nettype none

package rapr_pkg;

    localparam int unsigned HdrLen   = 6;
    localparam int unsigned PhaseW   = 9;

    localparam logic [7:0] BCAST_ADDR    = 8'hFF;
    localparam logic [7:0] SUM_GOOD      = 8'hFF;
    localparam logic [7:0] OWN_ADDR_RST  = 8'h01;

    // register indexes on the config port
    localparam logic [0:0] REG_OWN_ADDR  = 1'b0;

    // status codes
    localparam logic [2:0] ST_IGNORED = 3'd0;
    localparam logic [2:0] ST_HEADER  = 3'd1;
    localparam logic [2:0] ST_DATA    = 3'd2;
    localparam logic [2:0] ST_ACCEPT  = 3'd3;
    localparam logic [2:0] ST_BADSUM  = 3'd4;
    localparam logic [2:0] ST_DUP     = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] data_index;
        logic [7:0] payload_size;
        logic [7:0] channel;
        logic [7:0] ack_command;
        logic [7:0] sequence_id;
        logic [7:0] src_address;
        logic [7:0] dst_address;
    } t_result_data;

    typedef struct packed {
        logic [2:0]   status;
        t_result_data fields;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/rs485_addressed_packet_receiver.sv
// result path: the result of an accepted input item is registered and shows on the output the cycle after it is taken
// throughput: one item per cycle; the output register takes a new result
//   whenever it is empty or its current result is taken in the same cycle
// reset (synchronous, active low): hunting for an address, header bytes,
//   running sum and last sequence cleared, own address back to 0x01
// ============================================================================
// rs485_addressed_packet_receiver - multidrop packet parser with sum check
// Parses address-marked byte streams into header, data and checksum items,
// checks the 8-bit sum and rejects repeated sequence numbers.
// ============================================================================
`default_nettype none

module rs485_addressed_packet_receiver
    import rapr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // config port, own address register at byte address 0
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    // received bytes
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic        s_axis_tuser,   // [0] address_mark

    // parse results
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [63:0] m_axis_tdata,   // [7:0] dst_address, [15:8] src_address,
                                             // [23:16] sequence_id, [31:24] ack_command,
                                             // [39:32] channel, [47:40] payload_size,
                                             // [55:48] data_index, [63:56] data_byte
    output logic      [2:0]  m_axis_tuser    // [2:0] status
);

    logic [7:0]  r_own_addr;
    logic        cfg_wr;
    logic        in_take;
    t_result     result;
    logic        r_out_valid;
    t_result     r_out;

    // ------------------------------------------------------------------
    // config register
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr <= OWN_ADDR_RST;
        end else if (cfg_wr && paddr[2:2] == REG_OWN_ADDR) begin
            r_own_addr <= pwdata[7:0];
        end
    end

    // reads outside the register list return zero
    assign prdata = (paddr[2:2] == REG_OWN_ADDR) ? {24'd0, r_own_addr} : 32'd0;

    // ------------------------------------------------------------------
    // input side: take a byte whenever the output register frees up
    // ------------------------------------------------------------------
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    rapr_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (in_take),
        .i_rx_byte      (s_axis_tdata),
        .i_address_mark (s_axis_tuser),
        .i_own_address  (r_own_addr),
        .o_result       (result)
    );

    // ------------------------------------------------------------------
    // output register, one result per accepted item
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.fields;
    assign m_axis_tuser  = r_out.status;

endmodule

`default_nettype wire

FILE: sv/rapr_parser.sv
// ============================================================================
// rapr_parser - packet parse state and per-byte update
// Holds phase, header bytes, running sum and last accepted sequence; gives
// the result for the byte at its input and advances on each accepted item.
// ============================================================================
`default_nettype none

module rapr_parser
    import rapr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_address_mark,
    input  wire logic [7:0] i_own_address,
    output t_result         o_result
);

    logic [PhaseW-1:0] r_phase, n_phase;
    logic [7:0]        r_hdr [HdrLen];
    logic [7:0]        n_hdr [HdrLen];
    logic [7:0]        r_sum, n_sum;
    logic [7:0]        r_last_seq, n_last_seq;
    logic              r_last_valid, n_last_valid;

    logic [PhaseW-1:0] cur_phase;
    logic [PhaseW-1:0] data_end;
    logic [PhaseW-1:0] data_off;
    logic [7:0]        total;
    logic [2:0]        status;
    logic [7:0]        didx;
    logic [7:0]        dbyte;

    // a marked byte always restarts the hunt
    assign cur_phase = i_address_mark ? '0 : r_phase;
    assign data_end  = PhaseW'(HdrLen) + {1'b0, r_hdr[5]};
    assign data_off  = cur_phase - PhaseW'(HdrLen);
    assign total     = r_sum + i_rx_byte;

    always_comb begin
        n_phase      = cur_phase;
        n_hdr        = r_hdr;
        n_sum        = r_sum;
        n_last_seq   = r_last_seq;
        n_last_valid = r_last_valid;
        status       = ST_IGNORED;
        didx         = '0;
        dbyte        = '0;
        if (cur_phase == '0) begin
            if (i_rx_byte == i_own_address || i_rx_byte == BCAST_ADDR) begin
                n_hdr[0] = i_rx_byte;
                n_sum    = i_rx_byte;
                n_phase  = PhaseW'(1);
                status   = ST_HEADER;
            end
        end else if (cur_phase < PhaseW'(HdrLen)) begin
            n_hdr[cur_phase[2:0]] = i_rx_byte;
            n_sum   = total;
            n_phase = cur_phase + PhaseW'(1);
            status  = ST_HEADER;
        end else if (cur_phase < data_end) begin
            didx    = data_off[7:0];
            dbyte   = i_rx_byte;
            n_sum   = total;
            n_phase = cur_phase + PhaseW'(1);
            status  = ST_DATA;
        end else begin
            if (total != SUM_GOOD) begin
                status = ST_BADSUM;
            end else if (r_last_valid && r_hdr[2] == r_last_seq) begin
                status = ST_DUP;
            end else begin
                n_last_seq   = r_hdr[2];
                n_last_valid = 1'b1;
                status       = ST_ACCEPT;
            end
            n_phase = '0;
        end
    end

    assign o_result.status              = status;
    assign o_result.fields.dst_address  = n_hdr[0];
    assign o_result.fields.src_address  = n_hdr[1];
    assign o_result.fields.sequence_id  = n_hdr[2];
    assign o_result.fields.ack_command  = n_hdr[3];
    assign o_result.fields.channel      = n_hdr[4];
    assign o_result.fields.payload_size = n_hdr[5];
    assign o_result.fields.data_index   = didx;
    assign o_result.fields.data_byte    = dbyte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= '0;
            r_hdr        <= '{default: '0};
            r_sum        <= '0;
            r_last_seq   <= '0;
            r_last_valid <= 1'b0;
        end else if (i_en) begin
            r_phase      <= n_phase;
            r_hdr        <= n_hdr;
            r_sum        <= n_sum;
            r_last_seq   <= n_last_seq;
            r_last_valid <= n_last_valid;
        end
    end

endmodule

`default_nettype wire
